// ===== src/cvnt_pkg.sv =====
// cvnt_pkg: shared types, codes and hash constants of the trilinear value noise unit
// no dependencies; used by every module under src
`timescale 1ns / 1ps

package cvnt_pkg;

  localparam int CELL_SHIFT_DEF = 12;
  localparam int QUEUE_DEPTH    = 4;
  localparam int NUM_BANKS      = 7;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  localparam logic [1:0] TBL_X = 2'd0;
  localparam logic [1:0] TBL_Y = 2'd1;
  localparam logic [1:0] TBL_Z = 2'd2;
  localparam logic [1:0] TBL_W = 2'd3;

  localparam logic [63:0] HASH_MUL = 64'd65521;
  localparam logic [63:0] HASH_FIN = 64'd2147483647;

  // power of the hash multiplier, mod 2^64
  function automatic logic [63:0] m_pow(input int unsigned n);
    logic [63:0] r;
    r = 64'd1;
    for (int unsigned k = 0; k < n; k++) begin
      r = r * HASH_MUL;
    end
    return r;
  endfunction

  // the hash chain is linear mod 2^64, so each byte gets a fixed weight
  localparam logic [63:0] KX = (m_pow(6) - m_pow(4)) * HASH_FIN;
  localparam logic [63:0] KY = (m_pow(7) - m_pow(3)) * HASH_FIN;
  localparam logic [63:0] KZ = (m_pow(8) - m_pow(2)) * HASH_FIN;
  localparam logic [63:0] KW = (m_pow(5) - m_pow(1)) * HASH_FIN;
  localparam logic [63:0] KK = m_pow(8) * HASH_FIN;
  localparam logic [63:0] KS = m_pow(9) * HASH_FIN;
  localparam logic [31:0] KS_LO = KS[31:0];
  localparam logic [31:0] KS_HI = KS[63:32];

  typedef struct packed {
    logic            is_load;
    logic [7:0]      key;
    logic [1:0]      sel;
    logic [7:0]      idx;
    logic [7:0]      val;
    logic [1:0][7:0] addr_x;
    logic [1:0][7:0] addr_y;
    logic [1:0][7:0] addr_z;
    logic [7:0][7:0] addr_w;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== src/cvnt_ifs.sv =====
// cvnt_req_if, cvnt_rsp_if: valid/ready channels of the noise unit
// no dependencies
`timescale 1ns / 1ps

interface cvnt_req_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;
  logic [7:0]         noise_key;
  logic [1:0]         table_select;
  logic [7:0]         table_index;
  logic [7:0]         table_value;

  modport source (
    output valid, operation, coord_x, coord_y, coord_z, noise_key,
           table_select, table_index, table_value,
    input  ready
  );
  modport sink (
    input  valid, operation, coord_x, coord_y, coord_z, noise_key,
           table_select, table_index, table_value,
    output ready
  );
endinterface

interface cvnt_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

// ===== src/chunk_value_noise_trilinear_unit.sv =====
// channel  dir  payload                                            transfer when
// req      in   operation, coord_x/y/z, noise_key, table_*         req.valid && req.ready
// rsp      out  noise_value                                        rsp.valid && rsp.ready
// cfg      in   cfg_wr_data (world seed)                           cfg_wr_en
//
// one item per cycle sustained while rsp is not stalled; a sample passes from transfer in to
// result through the input register, queue, table read, then the hash and blend stages
// table loads take effect for every later item and give no result
// rsp stalls freeze the back pipeline; the queue and input register keep accepting until full
// rst is synchronous and clears control state and the seed; the tables need no clearing
// depends on cvnt_pkg, cvnt_ifs, cvnt_front, cvnt_queue, cvnt_back
`timescale 1ns / 1ps

module chunk_value_noise_trilinear_unit import cvnt_pkg::*; #(
  parameter int CELL_SHIFT = CELL_SHIFT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic signed [31:0] cfg_wr_data,
  cvnt_req_if.sink           req,
  cvnt_rsp_if.source         rsp
);

  localparam int QW = ENTRY_W + 3 * CELL_SHIFT;

  logic signed [31:0]         seed;
  logic                       f_push;
  entry_t                     f_entry;
  logic [2:0][CELL_SHIFT-1:0] f_frac;
  logic                       q_full;
  logic                       q_empty;
  logic                       q_pop;
  logic [QW-1:0]              q_data;
  entry_t                     b_entry;
  logic [2:0][CELL_SHIFT-1:0] b_frac;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cfg_wr_en) begin
      seed <= cfg_wr_data;
    end
  end

  cvnt_front #(.CELL_SHIFT(CELL_SHIFT)) u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_ready (!q_full),
    .q_push  (f_push),
    .q_entry (f_entry),
    .q_frac  (f_frac)
  );

  cvnt_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_data ({f_entry, f_frac}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  assign b_entry = entry_t'(q_data[QW-1 -: ENTRY_W]);
  assign b_frac  = q_data[3*CELL_SHIFT-1:0];

  cvnt_back #(.CELL_SHIFT(CELL_SHIFT)) u_back (
    .clk     (clk),
    .rst     (rst),
    .seed    (seed),
    .q_valid (!q_empty),
    .q_entry (b_entry),
    .q_frac  (b_frac),
    .q_pop   (q_pop),
    .rsp     (rsp)
  );

endmodule

// ===== src/cvnt_front.sv =====
// cvnt_front: input register, classifies items and forms table addresses and fractions
// depends on cvnt_pkg and cvnt_req_if
`timescale 1ns / 1ps

module cvnt_front import cvnt_pkg::*; #(
  parameter int CELL_SHIFT = CELL_SHIFT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  cvnt_req_if.sink                   req,
  input  logic                       q_ready,
  output logic                       q_push,
  output entry_t                     q_entry,
  output logic [2:0][CELL_SHIFT-1:0] q_frac
);

  localparam logic [31:0] FRAC_MASK = 32'((64'd1 << CELL_SHIFT) - 64'd1);
  localparam logic [31:0] STEP      = 32'(64'd1 << CELL_SHIFT);

  logic                       fv;
  logic [2:0][31:0]           pos;
  logic [2:0][31:0]           corner_lo;
  logic [2:0][31:0]           cell_lo;
  logic [2:0][31:0]           cell_hi;
  logic [7:0][15:0]           corner_xor;
  entry_t                     entry_next;
  logic [2:0][CELL_SHIFT-1:0] frac_next;

  always_comb begin
    pos[0] = req.coord_x;
    pos[1] = req.coord_y;
    pos[2] = req.coord_z;
    for (int a = 0; a < 3; a++) begin
      corner_lo[a] = pos[a] & ~FRAC_MASK;
      cell_lo[a]   = $signed(pos[a]) >>> CELL_SHIFT;
      // high corner wraps in 32 bits before the shift
      cell_hi[a]   = $signed(corner_lo[a] + STEP) >>> CELL_SHIFT;
      frac_next[a] = pos[a][CELL_SHIFT-1:0];
    end
    for (int i = 0; i < 8; i++) begin
      corner_xor[i] = (((i & 1) != 0) ? cell_hi[0][15:0] : cell_lo[0][15:0])
                    ^ (((i & 2) != 0) ? cell_hi[1][15:0] : cell_lo[1][15:0])
                    ^ (((i & 4) != 0) ? cell_hi[2][15:0] : cell_lo[2][15:0]);
    end

    entry_next.is_load   = (req.operation == OP_LOAD);
    entry_next.key       = req.noise_key;
    entry_next.sel       = req.table_select;
    entry_next.idx       = req.table_index;
    entry_next.val       = req.table_value;
    entry_next.addr_x[0] = cell_lo[0][7:0];
    entry_next.addr_x[1] = cell_hi[0][7:0];
    entry_next.addr_y[0] = cell_lo[1][7:0];
    entry_next.addr_y[1] = cell_hi[1][7:0];
    entry_next.addr_z[0] = cell_lo[2][7:0];
    entry_next.addr_z[1] = cell_hi[2][7:0];
    for (int i = 0; i < 8; i++) begin
      entry_next.addr_w[i] = corner_xor[i][15:8];
    end
  end

  assign req.ready = !fv || q_ready;
  assign q_push    = fv;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (req.ready) begin
      fv <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      q_entry <= entry_next;
      q_frac  <= frac_next;
    end
  end

endmodule

// ===== src/cvnt_queue.sv =====
// cvnt_queue: small register fifo between front and back
// depends on cvnt_pkg
`timescale 1ns / 1ps

module cvnt_queue import cvnt_pkg::*; #(
  parameter int W     = ENTRY_W,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("queue count past depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("pop from empty queue");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + CW'(1))
    else $error("queue count did not grow on transfer in");
`endif

endmodule

// ===== src/cvnt_back.sv =====
// cvnt_back: permutation table banks, hash pipeline and trilinear blend
// depends on cvnt_pkg and cvnt_rsp_if
`timescale 1ns / 1ps

module cvnt_back import cvnt_pkg::*; #(
  parameter int CELL_SHIFT = CELL_SHIFT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic signed [31:0]         seed,
  input  logic                       q_valid,
  input  entry_t                     q_entry,
  input  logic [2:0][CELL_SHIFT-1:0] q_frac,
  output logic                       q_pop,
  cvnt_rsp_if.source                 rsp
);

  localparam int PW = 19 + CELL_SHIFT;
  localparam logic [1:0] BANK_TBL [NUM_BANKS] =
    '{TBL_X, TBL_Y, TBL_Z, TBL_W, TBL_W, TBL_W, TBL_W};

  logic                 adv;
  logic [8:0]           vld;

  // table banks: x, y, z, then four copies of w
  logic [7:0]           mem  [NUM_BANKS][256];
  logic [7:0]           ra   [NUM_BANKS][2];
  logic [7:0]           rdat [NUM_BANKS][2];
  logic [NUM_BANKS-1:0] wr_en;

  logic [7:0]                 key0;
  logic [2:0][CELL_SHIFT-1:0] frac0, frac1, frac2, frac3;

  logic [1:0][63:0] tx, ty, tz;
  logic [7:0][63:0] tw;
  logic [63:0]      seed_lo;
  logic [31:0]      seed_hi;
  logic             seed_neg;
  logic [63:0]      keyp;

  logic [63:0]      base;
  logic [3:0][63:0] sxy;
  logic [7:0][63:0] szw;
  logic [63:0]      hsum [8];

  logic signed [16:0] cval [8];

  logic signed [17:0]   xd [4];
  logic signed [16:0]   xa [4];
  logic signed [PW-1:0] xp [4];
  logic [1:0][CELL_SHIFT-1:0] frac4, frac5;

  logic signed [16:0]   lx [4];
  logic signed [17:0]   yd [2];
  logic signed [16:0]   ya [2];
  logic signed [PW-1:0] yp [2];
  logic [CELL_SHIFT-1:0] frac6, frac7;

  logic signed [16:0]   ly [2];
  logic signed [17:0]   zd;
  logic signed [16:0]   za;
  logic signed [PW-1:0] zp;

  assign adv   = !rsp.valid || rsp.ready;
  assign q_pop = adv && q_valid;

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      ra[0][j] = q_entry.addr_x[j];
      ra[1][j] = q_entry.addr_y[j];
      ra[2][j] = q_entry.addr_z[j];
      for (int k = 0; k < 4; k++) begin
        ra[3 + k][j] = q_entry.addr_w[2 * k + j];
      end
    end
    for (int b = 0; b < NUM_BANKS; b++) begin
      wr_en[b] = q_pop && q_entry.is_load && (q_entry.sel == BANK_TBL[b]);
    end
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      if (wr_en[b]) begin
        mem[b][q_entry.idx] <= q_entry.val;
      end
      if (adv) begin
        rdat[b][0] <= mem[b][ra[b][0]];
        rdat[b][1] <= mem[b][ra[b][1]];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      hsum[i] = base + sxy[i & 3] + szw[i];
    end
    for (int k = 0; k < 4; k++) begin
      xd[k] = cval[2 * k + 1] - cval[2 * k];
    end
    for (int j = 0; j < 2; j++) begin
      yd[j] = lx[2 * j + 1] - lx[2 * j];
    end
    zd = ly[1] - ly[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      rsp.valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[7:0], q_pop && !q_entry.is_load};
      rsp.valid <= vld[8];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      key0  <= q_entry.key;
      frac0 <= q_frac;

      // weighted table bytes and the seed and key terms
      for (int j = 0; j < 2; j++) begin
        tx[j] <= 64'(rdat[0][j]) * KX;
        ty[j] <= 64'(rdat[1][j]) * KY;
        tz[j] <= 64'(rdat[2][j]) * KZ;
      end
      for (int i = 0; i < 8; i++) begin
        tw[i] <= 64'(rdat[3 + i / 2][i % 2]) * KW;
      end
      seed_lo  <= 64'($unsigned(seed)) * 64'(KS_LO);
      seed_hi  <= 32'(seed) * KS_HI;
      seed_neg <= seed[31];
      keyp     <= 64'(key0) * KK;
      frac1    <= frac0;

      base <= seed_lo + {seed_hi - (seed_neg ? KS_LO : 32'd0), 32'd0} + keyp;
      for (int j = 0; j < 4; j++) begin
        sxy[j] <= tx[j & 1] + ty[j >> 1];
      end
      for (int i = 0; i < 8; i++) begin
        szw[i] <= tz[i >> 2] + tw[i];
      end
      frac2 <= frac1;

      // corner value 2h - 65535
      for (int i = 0; i < 8; i++) begin
        cval[i] <= {~hsum[i][63], hsum[i][62:48], 1'b1};
      end
      frac3 <= frac2;

      for (int k = 0; k < 4; k++) begin
        xa[k] <= cval[2 * k];
        xp[k] <= xd[k] * $signed({1'b0, frac3[0]});
      end
      frac4 <= frac3[2:1];

      for (int k = 0; k < 4; k++) begin
        lx[k] <= 17'(xa[k] + (xp[k] >>> CELL_SHIFT));
      end
      frac5 <= frac4;

      for (int j = 0; j < 2; j++) begin
        ya[j] <= lx[2 * j];
        yp[j] <= yd[j] * $signed({1'b0, frac5[0]});
      end
      frac6 <= frac5[1];

      for (int j = 0; j < 2; j++) begin
        ly[j] <= 17'(ya[j] + (yp[j] >>> CELL_SHIFT));
      end
      frac7 <= frac6;

      za <= ly[0];
      zp <= zd * $signed({1'b0, frac7});

      rsp.noise_value <= 17'(za + (zp >>> CELL_SHIFT));
    end
  end

`ifndef ASSERT_OFF
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld)) else $error("pipeline moved during stall");
  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_entry.is_load) |=> !vld[0]) else $error("table load made a result");
  a_noise_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.noise_value >= -65535)) else $error("noise out of range");
`endif

endmodule

// ===== dv/testbench.sv =====
// testbench: self-checking bench for chunk_value_noise_trilinear_unit, with its own
// hash and trilinear blend predictor, random idling on both channels and seed phases
// depends on cvnt_pkg, cvnt_ifs and the unit under src
`timescale 1ns / 1ps

module testbench import cvnt_pkg::*;;

  localparam int          SHIFT          = CELL_SHIFT_DEF;
  localparam logic [31:0] FRAC_MASK      = (32'd1 << SHIFT) - 32'd1;
  localparam logic [31:0] CELL_EDGE      = 32'd1 << SHIFT;
  localparam logic [63:0] MULT_STEP      = 64'd65521;
  localparam logic [63:0] MULT_FINAL     = 64'd2147483647;
  localparam logic signed [16:0] NOISE_MIN = -17'sd65535;
  localparam int          SETTLE_CYCLES  = 16;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          NUM_PHASES     = 7;
  localparam int          PHASE_ITEMS    = 44;

  typedef struct packed {
    logic               op;
    logic [31:0]        x;
    logic [31:0]        y;
    logic [31:0]        z;
    logic [7:0]         key;
    logic [1:0]         sel;
    logic [7:0]         idx;
    logic [7:0]         val;
    logic               pinned;
    logic signed [16:0] want;
  } noise_req_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic signed [31:0] cfg_wr_data;

  cvnt_req_if req_ch ();
  cvnt_rsp_if rsp_ch ();

  chunk_value_noise_trilinear_unit #(.CELL_SHIFT(SHIFT)) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req_ch),
    .rsp         (rsp_ch)
  );

  logic [7:0]         perm_copy [0:3][0:255];
  logic [31:0]        seed_copy;
  logic signed [16:0] expected_noise [$];
  int errors     = 0;
  int n_samples  = 0;
  int n_loads    = 0;
  int n_seeds    = 0;
  int idle_odds  = 0;
  int stall_odds = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hash of one lattice corner, mapped onto -65535..65535
  function automatic longint corner_level(input logic [31:0] cx, cy, cz,
                                          input logic [7:0] key);
    logic [31:0] mix;
    logic [63:0] bx, by, bz, bw, v;
    mix = cx ^ cy ^ cz;
    bx = 64'(perm_copy[TBL_X][cx[7:0]]);
    by = 64'(perm_copy[TBL_Y][cy[7:0]]);
    bz = 64'(perm_copy[TBL_Z][cz[7:0]]);
    bw = 64'(perm_copy[TBL_W][mix[15:8]]);
    v = {{32{seed_copy[31]}}, seed_copy} * MULT_STEP + 64'(key);
    v = (v + bz) * MULT_STEP;
    v = (v + by) * MULT_STEP;
    v = (v + bx) * MULT_STEP;
    v = (v + bw) * MULT_STEP;
    v = (v - bx) * MULT_STEP;
    v = (v - by) * MULT_STEP;
    v = (v - bz) * MULT_STEP;
    v = (v - bw) * MULT_STEP;
    v = v * MULT_FINAL;
    return 2 * longint'({48'd0, v[63:48]}) - 65535;
  endfunction

  // a + floor((b - a) * f / 2^SHIFT)
  function automatic longint blend_step(input longint a, b, input logic [31:0] f);
    longint prod;
    prod = (b - a) * longint'({32'd0, f});
    return a + (prod >>> SHIFT);
  endfunction

  function automatic logic signed [16:0] noise_predict(input logic [31:0] x, y, z,
                                                       input logic [7:0] key);
    logic [31:0] pos [0:2];
    logic [31:0] c_lo [0:2];
    logic [31:0] c_hi [0:2];
    logic [31:0] frac [0:2];
    logic [31:0] lo;
    longint c [0:7];
    longint l0, l1, l2, l3, m0, m1, r;
    int i;
    pos[0] = x;
    pos[1] = y;
    pos[2] = z;
    for (i = 0; i < 3; i++) begin
      lo      = pos[i] & ~FRAC_MASK;
      frac[i] = pos[i] & FRAC_MASK;
      c_lo[i] = $signed(lo) >>> SHIFT;
      c_hi[i] = $signed(lo + CELL_EDGE) >>> SHIFT;
    end
    for (i = 0; i < 8; i++) begin
      c[i] = corner_level(i[0] ? c_hi[0] : c_lo[0], i[1] ? c_hi[1] : c_lo[1],
                          i[2] ? c_hi[2] : c_lo[2], key);
    end
    l0 = blend_step(c[0], c[1], frac[0]);
    l1 = blend_step(c[2], c[3], frac[0]);
    l2 = blend_step(c[4], c[5], frac[0]);
    l3 = blend_step(c[6], c[7], frac[0]);
    m0 = blend_step(l0, l1, frac[1]);
    m1 = blend_step(l2, l3, frac[1]);
    r  = blend_step(m0, m1, frac[2]);
    return 17'(r);
  endfunction

  function automatic logic [31:0] pick_coord();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 6))
      0, 1: ;
      2: r = (r & ~FRAC_MASK) + 32'($urandom_range(0, 4)) - 32'd2;
      3: r = (r & ~FRAC_MASK) | ($urandom_range(0, 1) ? FRAC_MASK : 32'd0);
      4: r = 32'($urandom_range(0, 40000)) - 32'd20000;
      default: begin
        case ($urandom_range(0, 4))
          0: r = 32'h0000_0000;
          1: r = 32'hFFFF_FFFF;
          2: r = 32'h7FFF_FFFF;
          3: r = 32'h8000_0000;
          default: r = 32'h7FFF_F000;
        endcase
      end
    endcase
    return r;
  endfunction

  // unused fields are random so they are shown to be ignored
  function automatic noise_req_t make_sample(input logic [31:0] x, y, z,
                                             input logic [7:0] key);
    noise_req_t it;
    it.op     = OP_SAMPLE;
    it.x      = x;
    it.y      = y;
    it.z      = z;
    it.key    = key;
    it.sel    = 2'($urandom);
    it.idx    = 8'($urandom);
    it.val    = 8'($urandom);
    it.pinned = 1'b0;
    it.want   = '0;
    return it;
  endfunction

  function automatic noise_req_t make_load(input logic [1:0] sel,
                                           input logic [7:0] idx, val);
    noise_req_t it;
    it.op     = OP_LOAD;
    it.x      = $urandom;
    it.y      = $urandom;
    it.z      = $urandom;
    it.key    = 8'($urandom);
    it.sel    = sel;
    it.idx    = idx;
    it.val    = val;
    it.pinned = 1'b0;
    it.want   = '0;
    return it;
  endfunction

  function automatic noise_req_t pinned(input noise_req_t it,
                                        input logic signed [16:0] want);
    noise_req_t r;
    r        = it;
    r.pinned = 1'b1;
    r.want   = want;
    return r;
  endfunction

  function automatic noise_req_t rand_sample();
    return make_sample(pick_coord(), pick_coord(), pick_coord(), 8'($urandom));
  endfunction

  task automatic push_item(input noise_req_t it);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.operation    <= it.op;
    req_ch.coord_x      <= it.x;
    req_ch.coord_y      <= it.y;
    req_ch.coord_z      <= it.z;
    req_ch.noise_key    <= it.key;
    req_ch.table_select <= it.sel;
    req_ch.table_index  <= it.idx;
    req_ch.table_value  <= it.val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (it.op == OP_LOAD) begin
      perm_copy[it.sel][it.idx] = it.val;
      n_loads++;
    end else begin
      expected_noise.push_back(it.pinned ? it.want
                                         : noise_predict(it.x, it.y, it.z, it.key));
      n_samples++;
    end
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (expected_noise.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] s);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= s;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    seed_copy = s;
    n_seeds++;
  endtask

  initial begin : stimulus
    noise_req_t  dir_tab [0:17];
    logic [31:0] seed_plan [0:NUM_PHASES-1];
    int          odds_plan [0:NUM_PHASES-1];
    int          k, n, ph;

    rst                 <= 1'b1;
    cfg_wr_en           <= 1'b0;
    cfg_wr_data         <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.operation    <= OP_SAMPLE;
    req_ch.coord_x      <= '0;
    req_ch.coord_y      <= '0;
    req_ch.coord_z      <= '0;
    req_ch.noise_key    <= '0;
    req_ch.table_select <= TBL_X;
    req_ch.table_index  <= '0;
    req_ch.table_value  <= '0;
    seed_copy = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    write_seed(32'h0000_0000);
    // every entry gets written before any sample reads it
    for (k = 0; k < 1024; k++) push_item(make_load(2'(k / 256), 8'(k % 256), 8'd0));

    // zero tables with zero seed and key hash every corner to the bottom value
    dir_tab[0]  = pinned(make_sample(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'd0),
                         NOISE_MIN);
    dir_tab[1]  = pinned(make_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd0),
                         NOISE_MIN);
    dir_tab[2]  = pinned(make_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'd0),
                         NOISE_MIN);
    dir_tab[3]  = pinned(make_sample(32'hFFFF_FFFF, 32'h0000_0FFF, 32'hFFFF_F000, 8'd0),
                         NOISE_MIN);
    dir_tab[4]  = make_sample(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'd255);
    dir_tab[5]  = make_load(TBL_X, 8'h00, 8'hFF);
    dir_tab[6]  = make_load(TBL_Y, 8'hFF, 8'h80);
    dir_tab[7]  = make_load(TBL_Z, 8'h00, 8'h01);
    dir_tab[8]  = make_load(TBL_W, 8'h00, 8'hAA);
    dir_tab[9]  = make_sample(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'd0);
    dir_tab[10] = make_sample(32'h0000_0FFF, 32'h0000_0FFF, 32'h0000_0FFF, 8'd1);
    dir_tab[11] = make_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0);
    dir_tab[12] = make_load(TBL_W, 8'hFF, 8'hFF);
    dir_tab[13] = make_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd255);
    dir_tab[14] = make_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'd128);
    dir_tab[15] = make_sample(32'h0000_1000, 32'hFFFF_F000, 32'h0000_0000, 8'd7);
    dir_tab[16] = make_load(TBL_X, 8'hFF, 8'h55);
    dir_tab[17] = make_sample(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 8'd80);
    for (k = 0; k < 18; k++) push_item(dir_tab[k]);

    seed_plan[0] = $urandom;
    seed_plan[1] = 32'h7FFF_FFFF;
    seed_plan[2] = 32'h8000_0000;
    seed_plan[3] = 32'hFFFF_FFFF;
    seed_plan[4] = $urandom;
    seed_plan[5] = $urandom;
    seed_plan[6] = $urandom;
    odds_plan    = '{4, 3, 8, 0, 2, 6, 0};

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      write_seed(seed_plan[ph]);
      idle_odds  = (ph == NUM_PHASES - 1) ? 0 : odds_plan[ph];
      stall_odds = idle_odds;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 4) == 0) begin
          push_item(make_load(2'($urandom), 8'($urandom), 8'($urandom)));
        end else begin
          push_item(rand_sample());
        end
      end
    end

    drain();
    $display("run covered %0d noise samples and %0d table writes across %0d seed values",
             n_samples, n_loads, n_seeds);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    rsp_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : rsp_check
    logic signed [16:0] want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_noise.size() == 0) begin
        errors++;
        $display("%0t: unexpected noise transfer: expected none, got %0d",
                 $time, rsp_ch.noise_value);
      end else begin
        want = expected_noise.pop_front();
        if (rsp_ch.noise_value !== want) begin
          errors++;
          $display("%0t: noise_value mismatch: expected %0d, got %0d",
                   $time, want, rsp_ch.noise_value);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
